### design/compass_heading_from_axes_unit_defines.svh
// ---------------------------------------------------------------------------
// compass heading unit assertion macros
// shared property wrappers for the port checker
// ---------------------------------------------------------------------------
`ifndef COMPASS_HEADING_FROM_AXES_UNIT_DEFINES_SVH
`define COMPASS_HEADING_FROM_AXES_UNIT_DEFINES_SVH

// same-cycle implication, checked while out of reset
`define CMPH_ASSERT_HOLDS(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("cmph: same-cycle property violated");

// next-cycle implication, checked while out of reset
`define CMPH_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("cmph: next-cycle property violated");

`endif

### design/cmph_pkg.sv
// ---------------------------------------------------------------------------
// cmph_pkg
// widths, angle constants, arctangent table and stage payload type
// ---------------------------------------------------------------------------
package cmph_pkg;

  localparam int AXIS_WIDTH    = 12;
  localparam int CORDIC_STAGES = 16;
  localparam int TABLE_LEN     = 24;
  localparam int NUM_STAGES    = (CORDIC_STAGES < TABLE_LEN) ? CORDIC_STAGES : TABLE_LEN;

  // axes are pre-scaled by 2^16; one bit for the quadrant negate, two for cordic gain
  localparam int SCALE_SHIFT = 16;
  localparam int EXT_W       = AXIS_WIDTH + 1;
  localparam int XY_W        = AXIS_WIDTH + SCALE_SHIFT + 3;

  // angle accumulator: 1/64 degree units with 12 fraction bits
  localparam int ANGLE_FRAC = 12;
  localparam int Z_W        = 27;
  localparam int ANG_W      = 16;
  localparam int HEAD_W     = 15;
  localparam int DECL_W     = 15;

  localparam logic signed [ANG_W-1:0] FULL_TURN    = 16'sd23040;
  localparam logic signed [ANG_W-1:0] HALF_TURN    = 16'sd11520;
  localparam logic signed [ANG_W-1:0] QUARTER_TURN = 16'sd5760;

  localparam logic signed [DECL_W-1:0] DECL_RESET = 15'sd79;
  localparam logic signed [DECL_W-1:0] DECL_MAX   = 15'sd11520;
  localparam logic signed [DECL_W-1:0] DECL_MIN   = -15'sd11520;

  // atan(2^-i) in 1/64 degree, scaled by 2^12
  localparam logic signed [Z_W-1:0] ATAN_TAB [TABLE_LEN] = '{
    27'sd11796480, 27'sd6963869, 27'sd3679517, 27'sd1867780,
    27'sd937515,   27'sd469214,  27'sd234664,  27'sd117339,
    27'sd58671,    27'sd29335,   27'sd14668,   27'sd7334,
    27'sd3667,     27'sd1833,    27'sd917,     27'sd458,
    27'sd229,      27'sd115,     27'sd57,      27'sd29,
    27'sd14,       27'sd7,       27'sd4,       27'sd2
  };

  typedef struct packed {
    logic signed [XY_W-1:0]  x;
    logic signed [XY_W-1:0]  y;
    logic signed [Z_W-1:0]   z;
    logic signed [ANG_W-1:0] base;     // quadrant offset, or exact angle on an axis
    logic                    special;  // axis case, cordic result ignored
  } cmph_item_t;

endpackage

### design/cmph_prep.sv
// ---------------------------------------------------------------------------
// cmph_prep
// axis cases, quadrant pre-rotation and scaling into the cordic format
// ---------------------------------------------------------------------------
module cmph_prep (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic signed [cmph_pkg::AXIS_WIDTH-1:0] x_axis_i,
  input  logic signed [cmph_pkg::AXIS_WIDTH-1:0] y_axis_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output cmph_pkg::cmph_item_t                out_item_o
);
  import cmph_pkg::*;

  logic signed [EXT_W-1:0] x_ext, y_ext, xr, yr;
  cmph_item_t              item_d, item_q;
  logic                    valid_q;

  assign x_ext = {x_axis_i[AXIS_WIDTH-1], x_axis_i};
  assign y_ext = {y_axis_i[AXIS_WIDTH-1], y_axis_i};

  always_comb begin
    xr             = x_ext;
    yr             = y_ext;
    item_d.base    = '0;
    item_d.special = 1'b0;
    if (y_axis_i == '0) begin
      item_d.special = 1'b1;
      item_d.base    = x_axis_i[AXIS_WIDTH-1] ? HALF_TURN : '0;
    end else if (x_axis_i == '0) begin
      item_d.special = 1'b1;
      item_d.base    = y_axis_i[AXIS_WIDTH-1] ? -QUARTER_TURN : QUARTER_TURN;
    end else if (x_axis_i[AXIS_WIDTH-1]) begin
      // rotate into the right half plane
      if (!y_axis_i[AXIS_WIDTH-1]) begin
        xr          = y_ext;
        yr          = -x_ext;
        item_d.base = QUARTER_TURN;
      end else begin
        xr          = -y_ext;
        yr          = x_ext;
        item_d.base = -QUARTER_TURN;
      end
    end
    item_d.x = {{(XY_W-EXT_W-SCALE_SHIFT){xr[EXT_W-1]}}, xr, {SCALE_SHIFT{1'b0}}};
    item_d.y = {{(XY_W-EXT_W-SCALE_SHIFT){yr[EXT_W-1]}}, yr, {SCALE_SHIFT{1'b0}}};
    item_d.z = '0;
  end

  assign in_ready_o  = !valid_q || out_ready_i;
  assign out_valid_o = valid_q;
  assign out_item_o  = item_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_ready_o) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      item_q <= item_d;
    end
  end

endmodule

### design/cmph_cordic.sv
// ---------------------------------------------------------------------------
// cmph_cordic
// vectoring cordic, one registered micro-rotation per stage
// ---------------------------------------------------------------------------
module cmph_cordic (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  cmph_pkg::cmph_item_t in_item_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output cmph_pkg::cmph_item_t out_item_o
);
  import cmph_pkg::*;

  cmph_item_t st_in [NUM_STAGES];
  cmph_item_t st_d  [NUM_STAGES];
  cmph_item_t st_q  [NUM_STAGES];
  logic       vld_in [NUM_STAGES];
  logic       vld_q  [NUM_STAGES];
  logic       rdy    [NUM_STAGES];

  for (genvar i = 0; i < NUM_STAGES; i++) begin : g_stage
    logic signed [XY_W-1:0] xin, yin, dx, dy;

    if (i == 0) begin : g_first
      assign st_in[i]  = in_item_i;
      assign vld_in[i] = in_valid_i;
    end else begin : g_mid
      assign st_in[i]  = st_q[i-1];
      assign vld_in[i] = vld_q[i-1];
    end

    if (i == NUM_STAGES - 1) begin : g_last
      assign rdy[i] = !vld_q[i] || out_ready_i;
    end else begin : g_inner
      assign rdy[i] = !vld_q[i] || rdy[i+1];
    end

    assign xin = st_in[i].x;
    assign yin = st_in[i].y;
    assign dx  = yin >>> i;
    assign dy  = xin >>> i;

    always_comb begin
      st_d[i] = st_in[i];
      if (!yin[XY_W-1]) begin
        st_d[i].x = xin + dx;
        st_d[i].y = yin - dy;
        st_d[i].z = st_in[i].z + ATAN_TAB[i];
      end else begin
        st_d[i].x = xin - dx;
        st_d[i].y = yin + dy;
        st_d[i].z = st_in[i].z - ATAN_TAB[i];
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[i] <= 1'b0;
      end else if (rdy[i]) begin
        vld_q[i] <= vld_in[i];
      end
    end

    always_ff @(posedge clk_i) begin
      if (rdy[i] && vld_in[i]) begin
        st_q[i] <= st_d[i];
      end
    end
  end

  assign in_ready_o  = rdy[0];
  assign out_valid_o = vld_q[NUM_STAGES-1];
  assign out_item_o  = st_q[NUM_STAGES-1];

endmodule

### design/cmph_post.sv
// ---------------------------------------------------------------------------
// cmph_post
// angle rounding, declination add and wrap into one turn
// ---------------------------------------------------------------------------
module cmph_post (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             decl_we_i,
  input  logic signed [cmph_pkg::DECL_W-1:0] decl_i,
  input  logic                             in_valid_i,
  output logic                             in_ready_o,
  input  cmph_pkg::cmph_item_t             in_item_i,
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output logic [cmph_pkg::HEAD_W-1:0]      heading_o
);
  import cmph_pkg::*;

  localparam logic signed [Z_W-1:0] RND_HALF = Z_W'(2 ** (ANGLE_FRAC - 1));
  localparam int                    RND_W    = Z_W - ANGLE_FRAC;

  logic signed [DECL_W-1:0] decl_q, decl_d;
  logic signed [Z_W-1:0]    z_rnd;
  logic signed [ANG_W-1:0]  rnd, ang_d, ang_q, sum, wrap;
  logic [HEAD_W-1:0]        heading_d, heading_q;
  logic                     va_q, vb_q, rdy_a, rdy_b;

  // saturate on write, same as saturating at use
  always_comb begin
    decl_d = decl_i;
    if (decl_i > DECL_MAX) begin
      decl_d = DECL_MAX;
    end else if (decl_i < DECL_MIN) begin
      decl_d = DECL_MIN;
    end
  end

  // round half up, floor shift
  assign z_rnd = in_item_i.z + RND_HALF;
  assign rnd   = {{(ANG_W-RND_W){z_rnd[Z_W-1]}}, z_rnd[Z_W-1:ANGLE_FRAC]};
  assign ang_d = in_item_i.special ? in_item_i.base : in_item_i.base + rnd;

  assign sum = ang_q + {{(ANG_W-DECL_W){decl_q[DECL_W-1]}}, decl_q};

  always_comb begin
    wrap = sum;
    if (sum < 0) begin
      wrap = sum + FULL_TURN;
    end else if (sum > FULL_TURN) begin
      wrap = sum - FULL_TURN;
    end
  end
  assign heading_d = wrap[HEAD_W-1:0];

  assign rdy_b       = !vb_q || out_ready_i;
  assign rdy_a       = !va_q || rdy_b;
  assign in_ready_o  = rdy_a;
  assign out_valid_o = vb_q;
  assign heading_o   = heading_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      decl_q <= DECL_RESET;
      va_q   <= 1'b0;
      vb_q   <= 1'b0;
    end else begin
      if (decl_we_i) begin
        decl_q <= decl_d;
      end
      if (rdy_a) begin
        va_q <= in_valid_i;
      end
      if (rdy_b) begin
        vb_q <= va_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy_a && in_valid_i) begin
      ang_q <= ang_d;
    end
    if (rdy_b && va_q) begin
      heading_q <= heading_d;
    end
  end

endmodule

### design/compass_heading_from_axes_unit.sv
// ---------------------------------------------------------------------------
// compass_heading_from_axes_unit
// heading from level magnetometer x/y axes, atan2 by pipelined cordic
// ---------------------------------------------------------------------------
//
//  channel   direction  handshake                       payload
//  --------  ---------  ------------------------------  ----------------------------
//  input     in         in_valid_i / in_stall_o         x_axis_i, y_axis_i
//  output    out        out_valid_o / out_stall_i       heading_o
//  config    in         declination_offset_we_i         declination_offset_i
//
//  one beat per cycle sustained while the output is not stalled; the path is one
//  prep stage, one cordic stage per micro-rotation, sixteen by default, and two post stages
//  every stage holds its beat on a stall and moves up into a free slot, so a
//  stalled output only backs up the input once all stages are full
//  reset clears all valid bits and loads the declination register with 79
//  no clearing pass and no warm-up after reset
//
module compass_heading_from_axes_unit (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // input beat
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic signed [cmph_pkg::AXIS_WIDTH-1:0] x_axis_i,
  input  logic signed [cmph_pkg::AXIS_WIDTH-1:0] y_axis_i,
  // result beat
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic [cmph_pkg::HEAD_W-1:0]         heading_o,
  // declination register
  input  logic                                declination_offset_we_i,
  input  logic signed [cmph_pkg::DECL_W-1:0]  declination_offset_i
);
  import cmph_pkg::*;

  // prep -> cordic
  logic       prep_ready, prep_valid, cordic_ready;
  cmph_item_t prep_item;
  // cordic -> post
  logic       cordic_valid, post_ready;
  cmph_item_t cordic_item;

  // axis cases are resolved here and then ride along the cordic unused
  cmph_prep u_prep (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (prep_ready),
    .x_axis_i    (x_axis_i),
    .y_axis_i    (y_axis_i),
    .out_valid_o (prep_valid),
    .out_ready_i (cordic_ready),
    .out_item_o  (prep_item)
  );

  // vector is driven onto the positive x axis, z collects the angle
  cmph_cordic u_cordic (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (prep_valid),
    .in_ready_o  (cordic_ready),
    .in_item_i   (prep_item),
    .out_valid_o (cordic_valid),
    .out_ready_i (post_ready),
    .out_item_o  (cordic_item)
  );

  // last stage of post is the output register
  cmph_post u_post (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .decl_we_i   (declination_offset_we_i),
    .decl_i      (declination_offset_i),
    .in_valid_i  (cordic_valid),
    .in_ready_o  (post_ready),
    .in_item_i   (cordic_item),
    .out_valid_o (out_valid_o),
    .out_ready_i (!out_stall_i),
    .heading_o   (heading_o)
  );

  assign in_stall_o = !prep_ready;

endmodule

### design/cmph_checker.sv
// ---------------------------------------------------------------------------
// cmph_checker
// port-level properties of the compass heading unit, bound to the top level
// ---------------------------------------------------------------------------
`include "compass_heading_from_axes_unit_defines.svh"

module cmph_checker (
  input logic                                clk_i,
  input logic                                rst_ni,
  input logic                                in_stall_o,
  input logic                                out_valid_o,
  input logic                                out_stall_i,
  input logic [cmph_pkg::HEAD_W-1:0]         heading_o
);

  // a stalled result beat stays offered
  `CMPH_ASSERT_NEXT(a_out_hold, out_valid_o && out_stall_i, out_valid_o)

  // and keeps its heading
  `CMPH_ASSERT_NEXT(a_out_stable, out_valid_o && out_stall_i, $stable(heading_o))

  // wrap always lands within one turn
  `CMPH_ASSERT_HOLDS(a_heading_range, out_valid_o, heading_o <= 15'd23040)

  // the pipeline only backs up when the result side stalls
  `CMPH_ASSERT_HOLDS(a_no_spurious_stall, !out_stall_i, !in_stall_o)

endmodule

bind compass_heading_from_axes_unit cmph_checker u_cmph_checker (.*);

### dv/compass_heading_from_axes_unit_checker.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// compass heading checker
// watches the reading and heading channels and the declination port, works
// out each heading from the accepted axes and compares it with the result
// ---------------------------------------------------------------------------
module compass_heading_from_axes_unit_checker (
  input  logic                                    clk_i,
  input  logic                                    rst_ni,
  input  logic                                    in_valid_i,
  input  logic                                    in_stall_i,
  input  logic signed [cmph_pkg::AXIS_WIDTH-1:0]  x_axis_i,
  input  logic signed [cmph_pkg::AXIS_WIDTH-1:0]  y_axis_i,
  input  logic                                    out_valid_i,
  input  logic                                    out_stall_i,
  input  logic [cmph_pkg::HEAD_W-1:0]             heading_i,
  input  logic                                    decl_we_i,
  input  logic signed [cmph_pkg::DECL_W-1:0]      decl_data_i,
  output int                                      fail_count_o,
  output int                                      pending_o
);

  localparam int AW = cmph_pkg::AXIS_WIDTH;
  localparam int DW = cmph_pkg::DECL_W;
  localparam int HW = cmph_pkg::HEAD_W;
  localparam int ARCTAN_LEN = 24;
  localparam int ROTATIONS  = (cmph_pkg::CORDIC_STAGES < ARCTAN_LEN) ?
                              cmph_pkg::CORDIC_STAGES : ARCTAN_LEN;
  localparam int REPORT_MAX = 10;

  localparam longint TURN_FULL    = 23040;
  localparam longint TURN_HALF    = 11520;
  localparam longint TURN_QUARTER = 5760;
  localparam longint FRAC_BITS    = 12;
  localparam logic signed [DW-1:0] DECL_AT_RESET = 15'sd79;

  // atan(2^-i) in 1/64 degree with 12 fraction bits
  localparam longint ARCTAN [ARCTAN_LEN] = '{
    11796480, 6963869, 3679517, 1867780, 937515, 469214, 234664, 117339,
    58671, 29335, 14668, 7334, 3667, 1833, 917, 458,
    229, 115, 57, 29, 14, 7, 4, 2
  };

  typedef struct {
    logic signed [AW-1:0] x;
    logic signed [AW-1:0] y;
    logic signed [DW-1:0] decl;
    logic [HW-1:0]        heading;
  } heading_expect_t;

  heading_expect_t   heading_q [$];
  logic signed [DW-1:0] decl_reg;
  int                errors = 0;

  function automatic logic [HW-1:0] predict_heading(input logic signed [AW-1:0] xa,
                                                    input logic signed [AW-1:0] ya,
                                                    input logic signed [DW-1:0] decl);
    longint x, y, z, t, dx, dy, base, angle, d, h;
    int     i;
    x = xa;
    y = ya;
    z = 0;
    base = 0;
    if (y == 0) begin
      angle = (x < 0) ? TURN_HALF : 0;
    end else if (x == 0) begin
      angle = (y > 0) ? TURN_QUARTER : -TURN_QUARTER;
    end else begin
      // left half plane: rotate by a quarter turn into the right half
      if (x < 0) begin
        t = x;
        if (y >= 0) begin
          x = y;
          y = -t;
          base = TURN_QUARTER;
        end else begin
          x = -y;
          y = t;
          base = -TURN_QUARTER;
        end
      end
      x = x * 65536;
      y = y * 65536;
      for (i = 0; i < ROTATIONS; i++) begin
        dx = y >>> i;
        dy = x >>> i;
        if (y >= 0) begin
          x = x + dx;
          y = y - dy;
          z = z + ARCTAN[i];
        end else begin
          x = x - dx;
          y = y + dy;
          z = z - ARCTAN[i];
        end
      end
      angle = base + ((z + (64'sd1 <<< (FRAC_BITS - 1))) >>> FRAC_BITS);
    end
    d = decl;
    if (d > TURN_HALF) d = TURN_HALF;
    if (d < -TURN_HALF) d = -TURN_HALF;
    h = angle + d;
    if (h < 0) h = h + TURN_FULL;
    if (h > TURN_FULL) h = h - TURN_FULL;
    return h[HW-1:0];
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    heading_expect_t want;
    if (!rst_ni) begin
      decl_reg = DECL_AT_RESET;
      heading_q.delete();
      pending_o <= 0;
      fail_count_o <= errors;
    end else begin
      if (decl_we_i) decl_reg = decl_data_i;
      if (in_valid_i && !in_stall_i) begin
        want.x = x_axis_i;
        want.y = y_axis_i;
        want.decl = decl_reg;
        want.heading = predict_heading(x_axis_i, y_axis_i, decl_reg);
        heading_q.push_back(want);
      end
      if (out_valid_i && !out_stall_i) begin
        if (heading_q.size() == 0) begin
          errors++;
          if (errors <= REPORT_MAX)
            $display("heading error at %0t: result %0d with no reading outstanding",
                     $time, heading_i);
        end else begin
          want = heading_q.pop_front();
          if (want.heading !== heading_i) begin
            errors++;
            if (errors <= REPORT_MAX)
              $display("heading error at %0t: x=%0d y=%0d decl=%0d expected %0d got %0d",
                       $time, want.x, want.y, want.decl, want.heading, heading_i);
          end
        end
      end
      pending_o <= heading_q.size();
      fail_count_o <= errors;
    end
  end

endmodule

### dv/compass_heading_from_axes_unit_tb.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// compass heading unit testbench
// drives axis readings in bursts against a stalling heading sink, sweeps the
// declination register through its extremes and lets the checker judge
// ---------------------------------------------------------------------------
module compass_heading_from_axes_unit_tb;

  localparam int AW = cmph_pkg::AXIS_WIDTH;
  localparam int DW = cmph_pkg::DECL_W;
  localparam int HW = cmph_pkg::HEAD_W;

  localparam int PHASE_READINGS = 125;   // random beats per declination setting
  localparam int HOLD_CYCLES    = 150;   // long sink hold-off, well past pipeline depth
  localparam int HOLD_SPACING   = 400;   // accepted readings between two hold-offs
  localparam int DRAIN_CYCLES   = 40;    // drain time before the verdict, past the pipeline depth
  localparam int STALL_LIMIT    = 4000;  // cycles with no beat or write before giving up

  typedef enum int {AXIS_FULL, AXIS_SMALL, AXIS_EXTREME} axis_pick_e;
  typedef enum int {SINK_OPEN, SINK_LIGHT, SINK_HALF, SINK_HEAVY} sink_mode_e;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  in_valid_i;
  logic                  in_stall_o;
  logic signed [AW-1:0]  x_axis_i;
  logic signed [AW-1:0]  y_axis_i;
  logic                  out_valid_o;
  logic                  out_stall_i;
  logic [HW-1:0]         heading_o;
  logic                  declination_offset_we_i;
  logic signed [DW-1:0]  declination_offset_i;

  int                    fail_count;
  int                    pending;
  int unsigned           readings_taken = 0;
  int unsigned           next_hold_at   = 300;

  // readings waiting to be streamed in the current phase
  logic signed [AW-1:0]  x_plan [$];
  logic signed [AW-1:0]  y_plan [$];

  // values that sit on the edges of the axis range
  localparam logic signed [AW-1:0] EDGE_VALUES [5] = '{-2048, -1, 0, 1, 2047};

  compass_heading_from_axes_unit dut (
    .clk_i                   (clk_i),
    .rst_ni                  (rst_ni),
    .in_valid_i              (in_valid_i),
    .in_stall_o              (in_stall_o),
    .x_axis_i                (x_axis_i),
    .y_axis_i                (y_axis_i),
    .out_valid_o             (out_valid_o),
    .out_stall_i             (out_stall_i),
    .heading_o               (heading_o),
    .declination_offset_we_i (declination_offset_we_i),
    .declination_offset_i    (declination_offset_i)
  );

  compass_heading_from_axes_unit_checker checker_i (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_i   (in_stall_o),
    .x_axis_i     (x_axis_i),
    .y_axis_i     (y_axis_i),
    .out_valid_i  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .heading_i    (heading_o),
    .decl_we_i    (declination_offset_we_i),
    .decl_data_i  (declination_offset_i),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  // 8 ns clock, starts low so the first rising edge falls at 4 ns
  always begin
    clk_i = 1'b0;
    #4;
    clk_i = 1'b1;
    #4;
  end

  // count accepted reading beats, the sink uses this to place its hold-offs
  always @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) readings_taken <= readings_taken + 1;
  end

  // one axis value of the requested flavor
  function automatic logic signed [AW-1:0] pick_axis(input axis_pick_e kind);
    int v;
    case (kind)
      AXIS_SMALL: begin
        v = $urandom_range(0, 16);
        v = v - 8;
      end
      AXIS_EXTREME: v = EDGE_VALUES[$urandom_range(0, 4)];
      default:      v = $urandom;
    endcase
    return v[AW-1:0];
  endfunction

  // stream the planned readings in bursts of random length with random gaps;
  // valid stays up between back-to-back beats, the payload holds under stall
  task automatic stream_plan();
    int burst;
    int gap;
    while (x_plan.size() != 0) begin
      // mostly short bursts, now and then a long run with no idling at all
      burst = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 120) : $urandom_range(1, 12);
      gap   = $urandom_range(0, 5);
      while (burst > 0 && x_plan.size() != 0) begin
        @(negedge clk_i);
        in_valid_i <= 1'b1;
        x_axis_i   <= x_plan.pop_front();
        y_axis_i   <= y_plan.pop_front();
        do @(posedge clk_i); while (in_stall_o);
        burst--;
      end
      if (gap > 0) begin
        @(negedge clk_i);
        in_valid_i <= 1'b0;
        repeat (gap - 1) @(negedge clk_i);
      end
    end
    @(negedge clk_i);
    in_valid_i <= 1'b0;
  endtask

  // block until every predicted heading has come out
  task automatic wait_all_headings();
    do @(posedge clk_i); while (pending != 0);
  endtask

  // one-cycle register write, only issued while the pipeline is empty
  task automatic write_declination(input logic signed [DW-1:0] value);
    @(negedge clk_i);
    declination_offset_we_i <= 1'b1;
    declination_offset_i    <= value;
    @(negedge clk_i);
    declination_offset_we_i <= 1'b0;
  endtask

  // heading sink: stall pattern of its own, plus long hold-offs while the
  // source keeps offering beats so the whole pipeline fills and backs up
  initial begin
    sink_mode_e mode;
    int         len;
    out_stall_i = 1'b0;
    @(posedge rst_ni);
    forever begin
      if (readings_taken >= next_hold_at) begin
        next_hold_at = next_hold_at + HOLD_SPACING;
        @(negedge clk_i);
        out_stall_i <= 1'b1;
        repeat (HOLD_CYCLES - 1) @(negedge clk_i);
      end
      mode = sink_mode_e'($urandom_range(0, 3));
      len  = $urandom_range(1, 40);
      repeat (len) begin
        @(negedge clk_i);
        case (mode)
          SINK_LIGHT: out_stall_i <= ($urandom_range(0, 3) == 0);
          SINK_HALF:  out_stall_i <= 1'($urandom_range(0, 1));
          SINK_HEAVY: out_stall_i <= ($urandom_range(0, 3) != 0);
          default:    out_stall_i <= 1'b0;
        endcase
      end
    end
  end

  // watchdog: ends the run once no beat or write has moved for too long
  initial begin
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < STALL_LIMIT) begin
      @(posedge clk_i);
      if (!rst_ni || declination_offset_we_i || (in_valid_i && !in_stall_o) ||
          (out_valid_o && !out_stall_i))
        idle_cycles = 0;
      else
        idle_cycles++;
    end
    $display("compass_heading_from_axes_unit: mismatch");
    $finish;
  end

  // stimulus and verdict
  initial begin
    logic signed [DW-1:0] decl_plan [$];
    logic signed [AW-1:0] xa;
    logic signed [AW-1:0] ya;
    int                   k;
    int                   v;

    rst_ni                  = 1'b0;
    in_valid_i              = 1'b0;
    x_axis_i                = '0;
    y_axis_i                = '0;
    declination_offset_we_i = 1'b0;
    declination_offset_i    = '0;
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // directed beats at the reset declination: zero vector, both axes at
    // both ends, the four diagonals at full and unit size, near-axis angles
    x_plan = '{0, 2047, -2048, 0, 0, 2047, -2048, 2047, -2048, 1, -1, 1, -1,
               2047, 2047, -2048, -2048, 1, -1, 1000, -1000, 3, -3};
    y_plan = '{0, 0, 0, 2047, -2048, 2047, -2048, -2048, 2047, 1, -1, -1, 1,
               1, -1, 1, -1, 2047, -2048, 577, -577, -4, 4};
    stream_plan();
    wait_all_headings();

    // declination sweep: zero, both legal ends (exactly a full turn and a
    // negative sum show up here), both out-of-range ends that saturate,
    // then random legal settings
    decl_plan = '{0, 11520, -11520, 16383, -16384};
    repeat (3) begin
      v = $urandom_range(0, 23040);
      v = v - 11520;
      decl_plan.push_back(v[DW-1:0]);
    end

    foreach (decl_plan[p]) begin
      write_declination(decl_plan[p]);
      // unit readings on each axis and the zero vector hit the wrap edges
      x_plan = '{-1, 1, 0, 0, 0};
      y_plan = '{0, 0, 1, -1, 0};
      repeat (PHASE_READINGS) begin
        k = $urandom_range(0, 99);
        if (k < 60) begin
          xa = pick_axis(AXIS_FULL);
          ya = pick_axis(AXIS_FULL);
        end else if (k < 72) begin
          xa = pick_axis(AXIS_SMALL);
          ya = pick_axis(AXIS_SMALL);
        end else if (k < 84) begin
          // on an axis
          if ($urandom_range(0, 1)) begin
            xa = '0;
            ya = pick_axis(AXIS_FULL);
          end else begin
            xa = pick_axis(AXIS_FULL);
            ya = '0;
          end
        end else if (k < 92) begin
          // on a diagonal
          xa = pick_axis(AXIS_FULL);
          ya = $urandom_range(0, 1) ? xa : -xa;
        end else begin
          xa = pick_axis(AXIS_EXTREME);
          ya = pick_axis(AXIS_EXTREME);
        end
        x_plan.push_back(xa);
        y_plan.push_back(ya);
      end
      stream_plan();
      wait_all_headings();
    end

    // let any stray result surface before the verdict
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (fail_count == 0)
      $display("compass_heading_from_axes_unit: match");
    else
      $display("compass_heading_from_axes_unit: mismatch");
    $finish;
  end

endmodule

### sim.f
+incdir+design
design/cmph_pkg.sv
design/cmph_prep.sv
design/cmph_cordic.sv
design/cmph_post.sv
design/compass_heading_from_axes_unit.sv
design/cmph_checker.sv
dv/compass_heading_from_axes_unit_checker.sv
dv/compass_heading_from_axes_unit_tb.sv
